// File: design/tbo_pkg.sv
// package for the triangle/box overlap test: widths, queue depth and register address constants
// no dependencies
`timescale 1ns / 1ps
package tbo_pkg;
    localparam int COORD_WIDTH = 24;
    localparam int EPS_WIDTH   = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int ADDR_WIDTH  = 1;
    localparam logic [ADDR_WIDTH-1:0] REG_DET_EPSILON = 1'b0;
endpackage

// File: design/triangle_box_overlap_test.sv
// top level: triangle/box strict overlap test with APB epsilon register
// depends on tbo_pkg, tbo_front, tbo_queue, tbo_back
// path from accept to result: front register, queue, back stages, output register
// throughput: one item per cycle unless stalled; back advances when its output is free
// reset: synchronous active low; clears control and det_epsilon to 0
`timescale 1ns / 1ps
module triangle_box_overlap_test #(
    parameter int COORD_WIDTH = tbo_pkg::COORD_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic psel, penable, pwrite,
    input  logic [tbo_pkg::ADDR_WIDTH+1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    input  logic i_valid,
    output logic o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_x, i_box_min_y, i_box_max_x, i_box_max_y,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_a_x, i_vertex_a_y, i_vertex_b_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_b_y, i_vertex_c_x, i_vertex_c_y,
    output logic o_valid,
    input  logic i_ready,
    output logic o_overlaps
);
    localparam int CW = COORD_WIDTH;
    localparam int QW = 2 + 10 * (CW + 1);
    logic [31:0] r_eps;
    logic f_v, f_r, f_dec, f_val, q_v, q_r;
    logic signed [CW:0] f_c [10], q_c [10];
    logic [QW-1:0] q_in, q_out;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[tbo_pkg::ADDR_WIDTH+1:2] == tbo_pkg::REG_DET_EPSILON) ? r_eps : '0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_eps <= '0;
        else if (psel && penable && pwrite
                 && paddr[tbo_pkg::ADDR_WIDTH+1:2] == tbo_pkg::REG_DET_EPSILON)
            r_eps <= pwdata;
    end

    tbo_front #(.CW(CW)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_bx0(i_box_min_x), .i_by0(i_box_min_y), .i_bx1(i_box_max_x), .i_by1(i_box_max_y),
        .i_x0(i_vertex_a_x), .i_y0(i_vertex_a_y), .i_x1(i_vertex_b_x), .i_y1(i_vertex_b_y),
        .i_x2(i_vertex_c_x), .i_y2(i_vertex_c_y),
        .o_valid(f_v), .i_ready(f_r), .o_decided(f_dec), .o_decision(f_val),
        .o_bx0(f_c[0]), .o_by0(f_c[1]), .o_bx1(f_c[2]), .o_by1(f_c[3]),
        .o_x0(f_c[4]), .o_y0(f_c[5]), .o_x1(f_c[6]), .o_y1(f_c[7]),
        .o_x2(f_c[8]), .o_y2(f_c[9]));

    // pack request for the queue and unpack its output
    always_comb begin
        q_in = {f_dec, f_val, (QW-2)'(0)};
        for (int i = 0; i < 10; i++) q_in[i*(CW+1) +: (CW+1)] = f_c[i];
        for (int i = 0; i < 10; i++) q_c[i] = q_out[i*(CW+1) +: (CW+1)];
    end

    tbo_queue #(.W(QW), .DEPTH(tbo_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n, .i_valid(f_v), .o_ready(f_r), .i_data(q_in),
        .o_valid(q_v), .i_ready(q_r), .o_data(q_out));

    tbo_back #(.CW(CW)) u_back (
        .i_clk, .i_rst_n, .i_eps(r_eps), .i_valid(q_v), .o_ready(q_r),
        .i_decided(q_out[QW-1]), .i_decision(q_out[QW-2]),
        .i_bx0(q_c[0]), .i_by0(q_c[1]), .i_bx1(q_c[2]), .i_by1(q_c[3]),
        .i_x0(q_c[4]), .i_y0(q_c[5]), .i_x1(q_c[6]), .i_y1(q_c[7]),
        .i_x2(q_c[8]), .i_y2(q_c[9]),
        .o_valid, .i_ready, .o_overlaps);
endmodule

// File: design/tbo_front.sv
// front part: accepts items, runs the box side reject, the vertex inside test,
// the edge on side test and registers sign-extended coordinates; depends on tbo_pkg
`timescale 1ns / 1ps
module tbo_front #(
    parameter int CW = tbo_pkg::COORD_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [CW-1:0] i_bx0, i_by0, i_bx1, i_by1,
    input  logic signed [CW-1:0] i_x0, i_y0, i_x1, i_y1, i_x2, i_y2,
    output logic                 o_valid,
    input  logic                 i_ready,
    // classification: decided, decision value
    output logic                 o_decided,
    output logic                 o_decision,
    output logic signed [CW:0]   o_bx0, o_by0, o_bx1, o_by1,
    output logic signed [CW:0]   o_x0, o_y0, o_x1, o_y1, o_x2, o_y2
);
    logic r_valid;
    logic r_decided, r_decision;
    logic signed [CW:0] r_c [10];
    logic signed [CW:0] c [10];
    logic rej, vin, side;

    assign o_ready = !r_valid || i_ready;

    // sign-extended coordinates
    always_comb begin
        c[0] = (CW+1)'(i_bx0); c[1] = (CW+1)'(i_by0);
        c[2] = (CW+1)'(i_bx1); c[3] = (CW+1)'(i_by1);
        c[4] = (CW+1)'(i_x0);  c[5] = (CW+1)'(i_y0);
        c[6] = (CW+1)'(i_x1);  c[7] = (CW+1)'(i_y1);
        c[8] = (CW+1)'(i_x2);  c[9] = (CW+1)'(i_y2);
    end

    function automatic logic on_side(input logic signed [CW:0] a1, b1, a2, b2, a0, lo, hi);
        on_side = (a1 == a0) && (a2 == a0) && !(b1 <= lo && b2 <= lo)
                  && !(b1 >= hi && b2 >= hi);
    endfunction

    function automatic logic vtx_in(input logic signed [CW:0] px, py);
        vtx_in = (c[0] < px) && (px < c[2]) && (c[1] < py) && (py < c[3]);
    endfunction

    // classify
    always_comb begin
        rej = (c[4] <= c[0] && c[6] <= c[0] && c[8] <= c[0])
            || (c[4] >= c[2] && c[6] >= c[2] && c[8] >= c[2])
            || (c[5] <= c[1] && c[7] <= c[1] && c[9] <= c[1])
            || (c[5] >= c[3] && c[7] >= c[3] && c[9] >= c[3]);
        vin = vtx_in(c[4], c[5]) || vtx_in(c[6], c[7]) || vtx_in(c[8], c[9]);
        side = 1'b0;
        for (int i = 0; i < 3; i++) begin
            int j, k;
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            if (on_side(c[4+2*i], c[5+2*i], c[4+2*j], c[5+2*j], c[0], c[1], c[3])
                && c[4+2*k] > c[0]) side = 1'b1;
            if (on_side(c[4+2*i], c[5+2*i], c[4+2*j], c[5+2*j], c[2], c[1], c[3])
                && c[4+2*k] < c[2]) side = 1'b1;
            if (on_side(c[5+2*i], c[4+2*i], c[5+2*j], c[4+2*j], c[1], c[0], c[2])
                && c[5+2*k] > c[1]) side = 1'b1;
            if (on_side(c[5+2*i], c[4+2*i], c[5+2*j], c[4+2*j], c[3], c[0], c[2])
                && c[5+2*k] < c[3]) side = 1'b1;
        end
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload register; side acceptance is kept as a late accept flag
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_decided  <= rej || vin;
            r_decision <= rej ? 1'b0 : (vin ? 1'b1 : side);
            for (int i = 0; i < 10; i++) r_c[i] <= c[i];
        end
    end

    assign o_valid = r_valid;
    assign o_decided = r_decided;
    assign o_decision = r_decision;
    assign o_bx0 = r_c[0]; assign o_by0 = r_c[1]; assign o_bx1 = r_c[2]; assign o_by1 = r_c[3];
    assign o_x0 = r_c[4]; assign o_y0 = r_c[5]; assign o_x1 = r_c[6]; assign o_y1 = r_c[7];
    assign o_x2 = r_c[8]; assign o_y2 = r_c[9];
endmodule

// File: design/tbo_queue.sv
// short queue between front and back parts
// depends on tbo_pkg
`timescale 1ns / 1ps
module tbo_queue #(
    parameter int W     = 8,
    parameter int DEPTH = tbo_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    logic [W-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [AW:0] r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;
    assign o_data = r_mem[r_rp];
    assign n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= n_wp;
            if (pop) r_rp <= n_rp;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (AW+1)'(DEPTH) && !pop) |=> r_cnt == (AW+1)'(DEPTH))
        else $error("queue lost entry");
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !pop) else $error("pop from empty queue");
endmodule

// File: design/tbo_back.sv
// back part: orientation tests (3 stages) and strict edge clip, output register
// depends on tbo_pkg
`timescale 1ns / 1ps
module tbo_back #(
    parameter int CW = tbo_pkg::COORD_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [tbo_pkg::EPS_WIDTH-1:0] i_eps,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_decided,
    input  logic                 i_decision,
    input  logic signed [CW:0]   i_bx0, i_by0, i_bx1, i_by1,
    input  logic signed [CW:0]   i_x0, i_y0, i_x1, i_y1, i_x2, i_y2,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_overlaps
);
    // doubled coordinates span CW+2 bits; differences CW+3
    localparam int DW = CW + 3;
    localparam int PW = 2 * DW;
    localparam int MW = PW + 1;
    // clip products: numerators and denominators of CW+2 bits
    localparam int NW = CW + 2;
    localparam int QW = 2 * NW;

    // points: tx/ty 0..2 vertices; px/py 0..3 corners, 4 centre
    logic signed [DW-1:0] tx [3], ty [3], px [5], py [5];
    logic s1_v, s2_v, s3_v, r_out_v;
    logic stall;

    assign stall = r_out_v && !i_ready;
    assign o_ready = !stall;
    assign o_valid = r_out_v;

    always_comb begin
        tx[0] = DW'(i_x0) <<< 1; ty[0] = DW'(i_y0) <<< 1;
        tx[1] = DW'(i_x1) <<< 1; ty[1] = DW'(i_y1) <<< 1;
        tx[2] = DW'(i_x2) <<< 1; ty[2] = DW'(i_y2) <<< 1;
        px[0] = DW'(i_bx0) <<< 1; py[0] = DW'(i_by0) <<< 1;
        px[1] = DW'(i_bx0) <<< 1; py[1] = DW'(i_by1) <<< 1;
        px[2] = DW'(i_bx1) <<< 1; py[2] = DW'(i_by0) <<< 1;
        px[3] = DW'(i_bx1) <<< 1; py[3] = DW'(i_by1) <<< 1;
        px[4] = DW'(i_bx0) + DW'(i_bx1); py[4] = DW'(i_by0) + DW'(i_by1);
    end

    // stage 1: register product operands of 16 orientations (1 tri + 5x3)
    logic signed [DW-1:0] r_ma [16], r_mb [16], r_mc [16], r_md [16];
    always_ff @(posedge i_clk) begin
        if (!stall) begin
            for (int k = 0; k < 16; k++) begin
                logic signed [DW-1:0] qx [3], qy [3];
                int p, s;
                p = (k == 0) ? 0 : (k - 1) / 3;
                s = (k == 0) ? 3 : (k - 1) % 3;
                for (int v = 0; v < 3; v++) begin
                    qx[v] = (v == s) ? px[p] : tx[v];
                    qy[v] = (v == s) ? py[p] : ty[v];
                end
                r_ma[k] <= qx[1] - qx[0]; r_mb[k] <= qy[2] - qy[0];
                r_mc[k] <= qy[1] - qy[0]; r_md[k] <= qx[2] - qx[0];
            end
        end
    end

    // clip path: margins and directions per edge, stage 1
    logic signed [NW-1:0] r_p [3][4], r_q [3][4];
    always_ff @(posedge i_clk) begin
        if (!stall) begin
            for (int e = 0; e < 3; e++) begin
                logic signed [NW-1:0] x1, y1, dx, dy;
                x1 = NW'((e == 0) ? i_x0 : (e == 1) ? i_x1 : i_x2);
                y1 = NW'((e == 0) ? i_y0 : (e == 1) ? i_y1 : i_y2);
                dx = NW'((e == 0) ? i_x1 : (e == 1) ? i_x2 : i_x0) - x1;
                dy = NW'((e == 0) ? i_y1 : (e == 1) ? i_y2 : i_y0) - y1;
                r_p[e][0] <= -dx; r_q[e][0] <= x1 - NW'(i_bx0);
                r_p[e][1] <= dx;  r_q[e][1] <= NW'(i_bx1) - x1;
                r_p[e][2] <= -dy; r_q[e][2] <= y1 - NW'(i_by0);
                r_p[e][3] <= dy;  r_q[e][3] <= NW'(i_by1) - y1;
            end
        end
    end

    logic r1_dec, r1_val;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) s1_v <= 1'b0;
        else if (!stall) s1_v <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (!stall) begin r1_dec <= i_decided; r1_val <= i_decision; end
    end

    // stage 2: products
    logic signed [PW-1:0] r_pl [16], r_pr [16];
    always_ff @(posedge i_clk) begin
        if (!stall) begin
            for (int k = 0; k < 16; k++) begin
                r_pl[k] <= PW'(r_ma[k]) * PW'(r_mb[k]);
                r_pr[k] <= PW'(r_mc[k]) * PW'(r_md[k]);
            end
        end
    end

    // clip: exact Liang-Barsky with fractions; bound candidates compared pairwise per edge
    // entering bounds u1 = max(0, -q/-p over p<0), leaving u2 = min(1, q/p over p>0)
    // strict interval nonempty iff every entering < every leaving and zero-p margins > 0
    // stage 2: cross products of every entering/leaving pair
    logic r_clip_ok [3][4][4];
    logic r_clip_zero [3];
    always_ff @(posedge i_clk) begin
        if (!stall) begin
            for (int e = 0; e < 3; e++) begin
                logic zok;
                zok = 1'b1;
                for (int a = 0; a < 4; a++) begin
                    if (r_p[e][a] == '0 && r_q[e][a] <= 0) zok = 1'b0;
                    for (int b = 0; b < 4; b++) begin
                        logic signed [QW-1:0] ln, rn;
                        // entering a: -q/-p (p<0); leaving b: q/p (p>0)
                        ln = QW'(-r_q[e][a]) * QW'(r_p[e][b]);
                        rn = QW'(r_q[e][b]) * QW'(-r_p[e][a]);
                        r_clip_ok[e][a][b] <= !(r_p[e][a] < 0 && r_p[e][b] > 0) || (ln < rn);
                    end
                    // against 0 and 1
                    if (r_p[e][a] < 0 && !(-r_q[e][a] < -r_p[e][a])) zok = 1'b0;
                    if (r_p[e][a] > 0 && !(r_q[e][a] > 0)) zok = 1'b0;
                end
                r_clip_zero[e] <= zok;
            end
        end
    end

    logic r2_dec, r2_val;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) s2_v <= 1'b0;
        else if (!stall) s2_v <= s1_v;
    end
    always_ff @(posedge i_clk) begin
        if (!stall) begin r2_dec <= r1_dec; r2_val <= r1_val; end
    end

    // stage 3: signs with tolerance, clip reduce
    logic [1:0] r_sg [16];
    logic r_clip;
    always_ff @(posedge i_clk) begin
        if (!stall) begin
            logic cl;
            cl = 1'b0;
            for (int k = 0; k < 16; k++) begin
                logic signed [MW-1:0] d;
                logic [MW-1:0] mag;
                d = MW'(r_pl[k]) - MW'(r_pr[k]);
                mag = d[MW-1] ? MW'(-d) : MW'(d);
                if (mag <= MW'({i_eps, 2'b00})) r_sg[k] <= 2'b00;
                else r_sg[k] <= d[MW-1] ? 2'b10 : 2'b01;
            end
            for (int e = 0; e < 3; e++) begin
                logic ok;
                ok = r_clip_zero[e];
                for (int a = 0; a < 4; a++)
                    for (int b = 0; b < 4; b++)
                        ok = ok && r_clip_ok[e][a][b];
                cl = cl || ok;
            end
            r_clip <= cl;
        end
    end

    logic r3_dec, r3_val;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) s3_v <= 1'b0;
        else if (!stall) s3_v <= s2_v;
    end
    always_ff @(posedge i_clk) begin
        if (!stall) begin r3_dec <= r2_dec; r3_val <= r2_val; end
    end

    // final decision
    logic pit, n_ovl, r_ovl;
    always_comb begin
        pit = 1'b0;
        for (int p = 0; p < 5; p++) begin
            if (r_sg[0] != 2'b00 && r_sg[1+3*p] == r_sg[0] && r_sg[2+3*p] == r_sg[0]
                && r_sg[3+3*p] == r_sg[0]) pit = 1'b1;
        end
        n_ovl = r3_dec ? r3_val : (pit || r_clip || r3_val);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (!stall) r_out_v <= s3_v;
    end
    always_ff @(posedge i_clk) begin
        if (!stall) r_ovl <= n_ovl;
    end
    assign o_overlaps = r_ovl;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |=> r_out_v) else $error("result dropped under stall");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!stall && s3_v) |=> r_out_v) else $error("pipeline lost item");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_v |-> o_ready) else $error("back stalled while empty");
endmodule
